// ===== rtl/core/stepper_half_step_driver_core_defines.svh =====
// ----------------------------------------------------------------------------
// Stepper half-step driver assertion macros
// Shared checks for the half-step driver core, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef STEPPER_HALF_STEP_DRIVER_CORE_DEFINES_SVH
`define STEPPER_HALF_STEP_DRIVER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SHSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SHSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/shsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper half-step driver package
// Item types and fixed constants shared by the driver core and its divider.
// ----------------------------------------------------------------------------
package shsd_pkg;

  localparam int unsigned PERIOD_SCALE = 75;
  // Timer period numerator: PERIOD_SCALE * 32768
  localparam int unsigned PERIOD_NUM   = PERIOD_SCALE * 32768;
  localparam int unsigned DVD_W        = $clog2(PERIOD_NUM + 1);
  localparam int unsigned CNT_W        = $clog2(DVD_W);
  localparam int unsigned MAG_W        = 17;
  localparam int unsigned PERIOD_W     = 13;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  localparam logic [MAG_W-1:0] MIN_MAG = 17'd328;

  localparam logic signed [15:0] OFF_DUTY   = -16'sd32768;
  localparam logic signed [15:0] STOP_DUTY  = -16'sd31130;
  localparam logic signed [15:0] RESET_DUTY = -16'sd29491;

  // floor(x/5) == (x * 52429) >> 18 for x < 2^18
  localparam logic [16:0] RECIP5    = 17'd52429;
  localparam int unsigned RECIP5_SH = 18;

  localparam logic REQ_SPEED = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic signed [15:0] speed;
    logic signed [15:0] torque;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] phase_a;
    logic signed [15:0] phase_a_neg;
    logic signed [15:0] phase_b;
    logic signed [15:0] phase_b_neg;
    logic [PERIOD_W-1:0] step_period;
    logic              timer_running;
    logic signed [31:0] step_position;
    logic [1:0]        heading;
  } out_item_t;

endpackage

// ===== rtl/core/shsd_div.sv =====
// ----------------------------------------------------------------------------
// Stepper half-step period divider
// Bit-serial restoring division of the fixed period numerator by the speed
// magnitude, one quotient bit per cycle, saturated to the period width.
// ----------------------------------------------------------------------------
module shsd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [shsd_pkg::MAG_W-1:0]    divisor,
  output logic                          done,
  output logic [shsd_pkg::PERIOD_W-1:0] quotient
);
  import shsd_pkg::*;

  logic [DVD_W-1:0] dvd_r;
  logic [DVD_W-1:0] quo_r;
  logic [MAG_W-1:0] rem_r;
  logic [MAG_W-1:0] div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [MAG_W:0]   trial;
  logic             fits;
  logic [MAG_W:0]   diff;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= DVD_W'(PERIOD_NUM);
      quo_r <= '0;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], fits};
      // remainder stays below the divisor, so the top bit drops
      rem_r <= fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = (|quo_r[DVD_W-1:PERIOD_W]) ? PERIOD_MAX : quo_r[PERIOD_W-1:0];

endmodule

// ===== rtl/core/stepper_half_step_driver_core.sv =====
// ----------------------------------------------------------------------------
// Stepper half-step driver core
// Eight half-step phase sequencer for a two-phase stepper with speed-driven
// timer period, drive levels and a signed step count.
// ----------------------------------------------------------------------------
//  channel  ports                           carries
//  in       in_valid / in_ready / in_data   speed command or step tick
//  out      out_valid / out_ready / out_data phase duties, period, position
//
//  A step tick, a stop-speed command and any tick before a direction go
//  from accept through the done state to the result. A running speed command
//  waits in the bit-serial period divider: one quotient bit per cycle, 22 bits.
//  One item is in work at a time; the next is taken while a result waits.
//  A stalled result holds the commit of the following item in its last cycle.
//  Synchronous active-low reset restores the stopped, no-direction state.
// ----------------------------------------------------------------------------
`include "stepper_half_step_driver_core_defines.svh"

module stepper_half_step_driver_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  shsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output shsd_pkg::out_item_t out_data
);
  import shsd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  function automatic logic signed [15:0] sat_add(logic signed [15:0] a,
                                                 logic signed [15:0] b);
    logic signed [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      return s[16] ? -16'sd32768 : 16'sd32767;
    end
    return s[15:0];
  endfunction

  logic [1:0]         state_r, state_nxt;
  logic               req_r;
  logic [MAG_W-1:0]   mag_r;
  logic               neg_r;
  logic               run_ok_r;
  logic signed [15:0] torque_r;
  logic [36:0]        prod_r;

  logic [3:0]          idx_r, idx_nxt;
  logic [1:0]          dir_r, dir_nxt;
  logic signed [15:0]  dsingle_r, dsingle_nxt;
  logic signed [15:0]  ddouble_r, ddouble_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                running_r, running_nxt;
  logic [31:0]         pos_r, pos_nxt;

  logic      out_valid_r;
  out_item_t out_r, out_nxt;

  logic [MAG_W-1:0] mag_c;
  logic             accept;
  logic             div_start;
  logic             div_done;
  logic [PERIOD_W-1:0] div_quo;
  logic             out_free;
  logic             commit;

  logic [MAG_W:0]     single_sum;
  logic [17:0]        double_q;
  logic [3:0]         cur_idx;
  logic signed [15:0] d1, d2;
  logic               fwd;

  assign mag_c = in_data.speed[15] ? (MAG_W'(0) - {1'b1, in_data.speed})
                                   : {1'b0, in_data.speed};

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign div_start = accept && (in_data.req_type == REQ_SPEED) && (mag_c >= MIN_MAG);
  assign out_free  = !out_valid_r || out_ready;
  assign commit    = (state_r == S_DONE) && out_free;

  shsd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (mag_c),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = div_start ? S_DIV : S_DONE;
      S_DIV:  if (div_done) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_data.req_type;
      mag_r    <= mag_c;
      neg_r    <= in_data.speed[15];
      run_ok_r <= mag_c >= MIN_MAG;
      torque_r <= in_data.torque;
    end
    // 6m * 1/5 for the two-phase duty, ready long before the divider ends
    prod_r <= 37'(({3'b0, mag_r} << 2) + ({3'b0, mag_r} << 1)) * 37'(RECIP5);
  end

  assign single_sum = {1'b0, mag_r} + {2'b0, mag_r[MAG_W-1:1]};
  assign double_q   = prod_r[RECIP5_SH +: 18];
  assign fwd        = (dir_r == DIR_FWD);
  assign d1         = sat_add(dsingle_r, torque_r);
  assign d2         = sat_add(ddouble_r, torque_r);
  assign cur_idx    = (idx_r == 4'd0 || idx_r > 4'd8) ? (fwd ? 4'd1 : 4'd8) : idx_r;

  always_comb begin
    idx_nxt     = idx_r;
    dir_nxt     = dir_r;
    dsingle_nxt = dsingle_r;
    ddouble_nxt = ddouble_r;
    period_nxt  = period_r;
    running_nxt = running_r;
    pos_nxt     = pos_r;
    out_nxt             = '0;
    out_nxt.phase_a     = OFF_DUTY;
    out_nxt.phase_a_neg = OFF_DUTY;
    out_nxt.phase_b     = OFF_DUTY;
    out_nxt.phase_b_neg = OFF_DUTY;

    if (req_r == REQ_SPEED) begin
      dir_nxt = neg_r ? DIR_FWD : DIR_BWD;
      if (run_ok_r) begin
        period_nxt  = div_quo;
        dsingle_nxt = 16'(single_sum - (MAG_W+1)'(32768));
        ddouble_nxt = 16'(double_q - 18'd32768);
        running_nxt = 1'b1;
      end else begin
        dsingle_nxt = STOP_DUTY;
        ddouble_nxt = STOP_DUTY;
        running_nxt = 1'b0;
      end
    end else if (dir_r == DIR_FWD || dir_r == DIR_BWD) begin
      case (cur_idx)
        4'd1: out_nxt.phase_a = d1;
        4'd2: begin
          out_nxt.phase_a = d2;
          out_nxt.phase_b = d2;
        end
        4'd3: out_nxt.phase_b = d1;
        4'd4: begin
          out_nxt.phase_a_neg = d2;
          out_nxt.phase_b     = d2;
        end
        4'd5: out_nxt.phase_a_neg = d1;
        4'd6: begin
          out_nxt.phase_a_neg = d2;
          out_nxt.phase_b_neg = d2;
        end
        4'd7: out_nxt.phase_b_neg = d1;
        default: begin
          out_nxt.phase_a     = d2;
          out_nxt.phase_b_neg = d2;
        end
      endcase
      // forward counts the position down and the index up
      idx_nxt = fwd ? cur_idx + 4'd1 : cur_idx - 4'd1;
      pos_nxt = fwd ? pos_r - 32'd1 : pos_r + 32'd1;
    end

    out_nxt.step_period   = period_nxt;
    out_nxt.timer_running = running_nxt;
    out_nxt.step_position = pos_nxt;
    out_nxt.heading       = dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= 4'd0;
      dir_r     <= DIR_NONE;
      dsingle_r <= RESET_DUTY;
      ddouble_r <= RESET_DUTY;
      period_r  <= '0;
      running_r <= 1'b0;
      pos_r     <= '0;
    end else if (commit) begin
      idx_r     <= idx_nxt;
      dir_r     <= dir_nxt;
      dsingle_r <= dsingle_nxt;
      ddouble_r <= ddouble_nxt;
      period_r  <= period_nxt;
      running_r <= running_nxt;
      pos_r     <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SHSD_ASSERT_NEXT(a_div_entered, div_start, state_r == S_DIV, "running speed item skipped the divider")
  `SHSD_ASSERT_NOW(a_div_done_in_div, div_done, state_r == S_DIV, "divider finished outside its wait state")
  `SHSD_ASSERT_NEXT(a_idle_tick_holds, commit && req_r == REQ_TICK && dir_r == DIR_NONE, $stable(pos_r) && $stable(idx_r), "tick without direction moved the motor")
  `SHSD_ASSERT_NOW(a_heading_legal, out_valid_r, out_r.heading != 2'd3, "illegal heading on result")

endmodule
